/* hw/rtl/bla_pkg.sv */
`default_nettype none

package bla_pkg;

    localparam int LATCH_W = 3;
    localparam int SLOT_W  = 4;
    localparam int CFG_IDX_W = 1;

    typedef logic [LATCH_W-1:0]   latch_t;
    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam latch_t LS_CANT_LOCK       = 3'd0;
    localparam latch_t LS_UNLOCKED        = 3'd1;
    localparam latch_t LS_LOCKING_PRESS   = 3'd2;
    localparam latch_t LS_LOCKED          = 3'd3;
    localparam latch_t LS_UNLOCKING_PRESS = 3'd4;

    localparam cfg_idx_t REG_TARGET_MAP = 1'd0;
    localparam cfg_idx_t REG_LOCK_MODE  = 1'd1;

    typedef struct packed {
        logic load;
        logic step;
    } latch_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/bla_latch.sv */
`default_nettype none

module bla_latch #(
    parameter int NUM_BUTTONS = 10
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  bla_pkg::latch_ctl_t                   ctl,
    input  logic [bla_pkg::LATCH_W*NUM_BUTTONS-1:0] load_value,
    input  logic [NUM_BUTTONS-1:0]                pressed,
    output logic [NUM_BUTTONS-1:0]                held
);

    import bla_pkg::*;

    latch_t state_reg  [NUM_BUTTONS];
    latch_t state_next [NUM_BUTTONS];
    latch_t step_state [NUM_BUTTONS];
    latch_t load_code  [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] busy;

    always_comb
    begin
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            load_code[i] = load_value[LATCH_W*i +: LATCH_W];
            case (state_reg[i])
                LS_UNLOCKED:
                    step_state[i] = pressed[i] ? LS_LOCKING_PRESS : LS_UNLOCKED;
                LS_LOCKED:
                    step_state[i] = pressed[i] ? LS_UNLOCKING_PRESS : LS_LOCKED;
                LS_LOCKING_PRESS:
                    step_state[i] = pressed[i] ? LS_LOCKING_PRESS : LS_LOCKED;
                LS_UNLOCKING_PRESS:
                    step_state[i] = pressed[i] ? LS_UNLOCKING_PRESS : LS_UNLOCKED;
                default:
                    step_state[i] = state_reg[i];
            endcase
            held[i] = pressed[i] || (step_state[i] == LS_LOCKED);
            busy[i] = (state_reg[i] == LS_LOCKING_PRESS)
                   || (state_reg[i] == LS_UNLOCKING_PRESS);
            if (ctl.load)
            begin
                state_next[i] = (load_code[i] > LS_UNLOCKING_PRESS) ? LS_CANT_LOCK
                                                                    : load_code[i];
            end
            else if (ctl.step)
            begin
                state_next[i] = step_state[i];
            end
            else
            begin
                state_next[i] = state_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                state_reg[i] <= LS_CANT_LOCK;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                state_reg[i] <= state_next[i];
            end
        end
    end

    a_release_settles: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.step && !ctl.load && (pressed == '0)) |=> (busy == '0))
        else $error("latch left mid-press after full release");

    a_press_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (pressed == '1) |-> (held == '1))
        else $error("pressed button not held");

endmodule

`default_nettype wire

/* hw/rtl/bla_remap.sv */
`default_nettype none

module bla_remap #(
    parameter int NUM_BUTTONS = 10
) (
    input  logic [NUM_BUTTONS-1:0]                 held,
    input  logic [bla_pkg::SLOT_W*NUM_BUTTONS-1:0] target_map,
    output logic [NUM_BUTTONS-1:0]                 mapped
);

    import bla_pkg::*;

    slot_t slot [NUM_BUTTONS];

    always_comb
    begin
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            slot[i] = target_map[SLOT_W*i +: SLOT_W];
            if ({1'b0, slot[i]} >= (SLOT_W+1)'(NUM_BUTTONS))
            begin
                slot[i] = SLOT_W'(i);
            end
        end
        for (int j = 0; j < NUM_BUTTONS; j++)
        begin
            mapped[j] = 1'b0;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                mapped[j] = mapped[j] | (held[i] & (slot[i] == SLOT_W'(j)));
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/button_latch_and_remap.sv */
// Button latch and remap.
// Input channel: in_valid/in_ready carry one poll item, pressed_mask, with
// bit i high while physical button i is held. Each button runs a latch
// that a press-and-release toggles between unlocked and locked; a button
// counts as held while pressed or locked. The held mask passes through the
// target_map crossbar and leaves on out_valid/out_ready as mapped_mask.
// out_valid rises in the cycle after acceptance. Throughput: one item per
// cycle; the latch update and the crossbar sit between the latch registers
// and the result register, so the latch loop closes through the latch registers alone.
// A held result does not block input while the receiver takes it in the
// same cycle; if out_ready stays low, in_ready drops and the result holds.
// Configuration: cfg_wr_en with cfg_index 0 writes target_map (four bits per
// source), index 1 loads every latch from three-bit codes (five up: cant-lock).
// Reset: all latches cant-lock, target_map identity, output empty.
`default_nettype none

module button_latch_and_remap #(
    parameter int NUM_BUTTONS = 10
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [NUM_BUTTONS-1:0]                 pressed_mask,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [NUM_BUTTONS-1:0]                 mapped_mask,
    input  logic                                   cfg_wr_en,
    input  bla_pkg::cfg_idx_t                      cfg_index,
    input  logic [bla_pkg::SLOT_W*NUM_BUTTONS-1:0] cfg_wdata
);

    import bla_pkg::*;

    localparam int MAP_W  = SLOT_W * NUM_BUTTONS;
    localparam int LOAD_W = LATCH_W * NUM_BUTTONS;

    logic [MAP_W-1:0]       target_map_reg;
    logic [NUM_BUTTONS-1:0] mapped_mask_reg;
    logic [NUM_BUTTONS-1:0] mapped_mask_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [NUM_BUTTONS-1:0] held;
    logic                   accept;
    latch_ctl_t             latch_ctl;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign latch_ctl.load = cfg_wr_en && (cfg_index == REG_LOCK_MODE);
    assign latch_ctl.step = accept;

    bla_latch #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) u_latch (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (latch_ctl),
        .load_value(cfg_wdata[LOAD_W-1:0]),
        .pressed   (pressed_mask),
        .held      (held)
    );

    bla_remap #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) u_remap (
        .held      (held),
        .target_map(target_map_reg),
        .mapped    (mapped_mask_next)
    );

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                target_map_reg[SLOT_W*i +: SLOT_W] <= SLOT_W'(i);
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en && (cfg_index == REG_TARGET_MAP))
            begin
                target_map_reg <= cfg_wdata;
            end
        end
    end

    // hold the result until taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mapped_mask_reg <= mapped_mask_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign mapped_mask = mapped_mask_reg;

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted item produced no result");

    a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !accept) |=> !out_valid)
        else $error("result repeated after being taken");

    a_idle_buttons_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (held == '0)) |=> (mapped_mask == '0))
        else $error("result set with no button held");

endmodule

`default_nettype wire
